### design/rlh_pkg.sv
// ----------------------------------------------------------------------------
// rlh_pkg
// Shared types, constants and helpers of the RGB and luma histogram block.
// ----------------------------------------------------------------------------
package rlh_pkg;

    localparam int COUNT_BITS = 24;
    localparam int NUM_BINS   = 256;
    localparam int NUM_CH     = 4;
    localparam int BIN_BITS   = $clog2(NUM_BINS);
    localparam int OUT_BITS   = 24;
    localparam int PIX_BITS   = 8;
    localparam int KIND_BITS  = 2;

    localparam logic [KIND_BITS-1:0] KIND_ACC   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_GRAY  = 3;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [BIN_BITS-1:0]   bin_t;
    typedef logic [OUT_BITS-1:0]   out_cnt_t;

    localparam count_t CNT_MAX  = '1;
    localparam bin_t   BIN_LAST = bin_t'(NUM_BINS - 1);

    typedef enum logic [1:0] {
        OP_ACC,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } st_t;

    typedef struct packed {
        op_t                    op;
        logic [NUM_CH-1:0][BIN_BITS-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [PIX_BITS-1:0]  red;
        logic [PIX_BITS-1:0]  green;
        logic [PIX_BITS-1:0]  blue;
        logic [PIX_BITS-1:0]  bin;
    } in_word_t;

    typedef struct packed {
        out_cnt_t red_count;
        out_cnt_t green_count;
        out_cnt_t blue_count;
        out_cnt_t gray_count;
        out_cnt_t peak_red;
        out_cnt_t peak_green;
        out_cnt_t peak_blue;
        out_cnt_t peak_gray;
        logic     saturated;
    } out_word_t;

    // low OUT_BITS bits of a counter, zero extended when the counter is narrower
    function automatic out_cnt_t to_out(input count_t c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

### design/rlh_in_if.sv
// ----------------------------------------------------------------------------
// rlh_in_if
// Valid/ready channel carrying one input word of the histogram block.
// ----------------------------------------------------------------------------
interface rlh_in_if;
    import rlh_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/rlh_out_if.sv
// ----------------------------------------------------------------------------
// rlh_out_if
// Valid/ready channel carrying one result word of the histogram block.
// ----------------------------------------------------------------------------
interface rlh_out_if;
    import rlh_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/rlh_front.sv
// ----------------------------------------------------------------------------
// rlh_front
// Accepts input words, decodes the kind and computes the luma bin.
// ----------------------------------------------------------------------------
module rlh_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          init_busy,
    rlh_in_if.sink        item,
    output logic          push_valid,
    input  logic          push_ready,
    output rlh_pkg::cmd_t push_data
);
    import rlh_pkg::*;

    logic              vld_reg;
    logic              vld_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              take;
    logic [12:0]       luma_sum;

    assign item.ready = !init_busy && (!vld_reg || push_ready);
    assign take       = item.valid && item.ready;

    // gray = (11r + 16g + 5b) / 32
    assign luma_sum = 13'(item.data.red) * 13'd11 + 13'(item.data.green) * 13'd16
                    + 13'(item.data.blue) * 13'd5;

    always_comb
    begin
        vld_next = vld_reg;
        cmd_next = cmd_reg;
        if (push_valid && push_ready)
        begin
            vld_next = 1'b0;
        end
        if (take)
        begin
            vld_next = 1'b1;
            unique case (item.data.kind)
                KIND_ACC:
                begin
                    cmd_next.op           = OP_ACC;
                    cmd_next.idx[CH_RED]   = item.data.red;
                    cmd_next.idx[CH_GREEN] = item.data.green;
                    cmd_next.idx[CH_BLUE]  = item.data.blue;
                    cmd_next.idx[CH_GRAY]  = luma_sum[12:5];
                end
                KIND_READ:
                begin
                    cmd_next.op  = OP_READ;
                    cmd_next.idx = {NUM_CH{item.data.bin}};
                end
                KIND_CLEAR:
                begin
                    cmd_next.op  = OP_CLEAR;
                    cmd_next.idx = '0;
                end
                default:
                begin
                    cmd_next.op  = OP_NOP;
                    cmd_next.idx = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign push_valid = vld_reg;
    assign push_data  = cmd_reg;

endmodule

### design/rlh_queue.sv
// ----------------------------------------------------------------------------
// rlh_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module rlh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rlh_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rlh_pkg::cmd_t pop_data
);
    import rlh_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/rlh_back.sv
// ----------------------------------------------------------------------------
// rlh_back
// Executes commands: bin memories, peak registers, clear sweep, result register.
// ----------------------------------------------------------------------------
module rlh_back (
    input  logic          clk,
    input  logic          rst_n,
    output logic          init_busy,
    input  logic          q_valid,
    output logic          q_pop,
    input  rlh_pkg::cmd_t q_data,
    rlh_out_if.source     result
);
    import rlh_pkg::*;

    count_t    hist_mem [NUM_CH][NUM_BINS];
    count_t    rd_data_reg [NUM_CH];

    st_t       state_reg;
    st_t       state_next;
    bin_t      ptr_reg;
    bin_t      ptr_next;
    cmd_t      cmd_reg;
    cmd_t      cmd_next;
    count_t    peak_reg [NUM_CH];
    count_t    peak_next [NUM_CH];
    logic      sat_reg;
    logic      sat_next;
    logic      res_vld_reg;
    logic      res_vld_next;
    out_word_t res_data_reg;
    out_word_t res_data_next;

    logic      out_free;
    logic      mem_we;
    bin_t      wr_addr [NUM_CH];
    count_t    wr_data [NUM_CH];
    count_t    inc [NUM_CH];
    count_t    res_cnt [NUM_CH];
    count_t    res_pk [NUM_CH];
    logic      res_sat;
    logic      res_load;
    logic      sweep_last;

    assign out_free   = !res_vld_reg || result.ready;
    assign sweep_last = (ptr_reg == BIN_LAST);
    assign init_busy  = (state_reg == ST_INIT);

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            inc[c] = (rd_data_reg[c] != CNT_MAX) ? rd_data_reg[c] + count_t'(1)
                                                 : rd_data_reg[c];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        cmd_next      = cmd_reg;
        peak_next     = peak_reg;
        sat_next      = sat_reg;
        res_vld_next  = res_vld_reg;
        res_data_next = res_data_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        res_load      = 1'b0;
        res_sat       = sat_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            wr_addr[c] = ptr_reg;
            wr_data[c] = '0;
            res_cnt[c] = '0;
            res_pk[c]  = peak_reg[c];
        end
        if (res_vld_reg && result.ready)
        begin
            res_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + bin_t'(1);
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    unique case (q_data.op)
                        OP_ACC, OP_READ:
                        begin
                            state_next = ST_EXEC;
                        end
                        OP_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_NOP:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
                if (cmd_reg.op == OP_ACC)
                begin
                    mem_we = 1'b1;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        wr_addr[c]   = cmd_reg.idx[c];
                        wr_data[c]   = inc[c];
                        peak_next[c] = (inc[c] > peak_reg[c]) ? inc[c] : peak_reg[c];
                        res_pk[c]    = peak_next[c];
                        if (inc[c] == CNT_MAX)
                        begin
                            sat_next = 1'b1;
                        end
                    end
                    res_sat = sat_next;
                end
                else
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        res_cnt[c] = rd_data_reg[c];
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + bin_t'(1);
                if (sweep_last)
                begin
                    res_load   = 1'b1;
                    sat_next   = 1'b0;
                    res_sat    = 1'b0;
                    state_next = ST_IDLE;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        peak_next[c] = '0;
                        res_pk[c]    = '0;
                    end
                end
            end
        endcase

        if (res_load)
        begin
            res_vld_next              = 1'b1;
            res_data_next.red_count   = to_out(res_cnt[CH_RED]);
            res_data_next.green_count = to_out(res_cnt[CH_GREEN]);
            res_data_next.blue_count  = to_out(res_cnt[CH_BLUE]);
            res_data_next.gray_count  = to_out(res_cnt[CH_GRAY]);
            res_data_next.peak_red    = to_out(res_pk[CH_RED]);
            res_data_next.peak_green  = to_out(res_pk[CH_GREEN]);
            res_data_next.peak_blue   = to_out(res_pk[CH_BLUE]);
            res_data_next.peak_gray   = to_out(res_pk[CH_GRAY]);
            res_data_next.saturated   = res_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            ptr_reg     <= '0;
            sat_reg     <= 1'b0;
            res_vld_reg <= 1'b0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                peak_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            sat_reg     <= sat_next;
            res_vld_reg <= res_vld_next;
            peak_reg    <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        res_data_reg <= res_data_next;
    end

    // bin memories: one write and one registered read per channel
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (mem_we)
            begin
                hist_mem[c][wr_addr[c]] <= wr_data[c];
            end
            rd_data_reg[c] <= hist_mem[c][q_data.idx[c]];
        end
    end

    assign result.valid = res_vld_reg;
    assign result.data  = res_data_reg;

    a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !res_vld_reg)
        else $error("result register busy while executing");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && out_free))
        else $error("command popped outside idle");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && sweep_last) |=>
        (peak_reg[CH_RED] == '0 && peak_reg[CH_GRAY] == '0 && !sat_reg && res_vld_reg))
        else $error("clear did not zero peaks and flag");

    a_exec_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $past(q_pop))
        else $error("execute without a popped command");

endmodule

### design/rgb_luma_histogram.sv
// ----------------------------------------------------------------------------
// rgb_luma_histogram
// Red, green, blue and luma histograms of 256 bins with running peak counts.
//
//   channel   dir   word        notes
//   item      in    in_word_t   kind 0 pixel, 1 read bin, 2 clear, 3 no-op
//   result    out   out_word_t  one word per item, counts zero unless read
//
// In the back end a pixel or read item is a bin memory read, then an update or
// report. A no-op is reported as it is popped; a clear is popped, then sweeps
// one bin a cycle. After reset a clearing pass runs; item.ready stays
// low meanwhile. A front register and a two-entry queue keep taking items
// while a result waits on result.ready.
// ----------------------------------------------------------------------------
module rgb_luma_histogram (
    input  logic      clk,
    input  logic      rst_n,
    rlh_in_if.sink    item,
    rlh_out_if.source result
);
    import rlh_pkg::*;

    logic init_busy;
    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    rlh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .init_busy  (init_busy),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rlh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rlh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_busy (init_busy),
        .q_valid   (pop_valid),
        .q_pop     (pop_ready),
        .q_data    (pop_data),
        .result    (result)
    );

endmodule

### test/tb_rgb_luma_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_luma_histogram
// Sends pixel, read, clear and no-op words to the histogram block with
// random gaps on the item and result channels. Each result word is checked
// field by field against a local copy of the four histograms, the peaks and
// the saturation flag.
// ----------------------------------------------------------------------------
module tb_rgb_luma_histogram;
    import rlh_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_NOP = 2'd3;
    localparam int NUM_RANDOM   = 650;
    localparam int NUM_COLORS   = 6;
    localparam int MAX_GAP      = 8;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_FIELDS   = 9;

    logic clk;
    logic rst_n;

    rlh_in_if  item_ch ();
    rlh_out_if result_ch ();

    rgb_luma_histogram dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    count_t      bin_counts [NUM_CH][NUM_BINS];
    count_t      peak_counts [NUM_CH];
    logic        sat_seen;
    in_word_t    item_words_q [$];
    out_word_t   expected_reports_q [$];
    int unsigned items_taken   = 0;
    int unsigned results_taken = 0;
    int unsigned src_seen      = 0;
    int unsigned snk_seen      = 0;
    int unsigned err_count     = 0;
    int unsigned idle_cycles   = 0;
    int          src_gap       = 0;
    int          snk_stall     = 0;
    bit          src_quiet     = 1'b0;
    bit          snk_quiet     = 1'b0;
    logic [PIX_BITS-1:0] palette [NUM_COLORS][3];
    string       field_names [NUM_FIELDS] = '{"red_count", "green_count", "blue_count",
        "gray_count", "peak_red", "peak_green", "peak_blue", "peak_gray", "saturated"};

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bin_t luma_bin(input logic [PIX_BITS-1:0] r, g, b);
        int unsigned weighted;
        weighted = 11 * r + 16 * g + 5 * b;
        return bin_t'(weighted >> 5);
    endfunction

    task automatic clear_histograms();
        for (int c = 0; c < NUM_CH; c++)
        begin
            peak_counts[c] = '0;
            for (int i = 0; i < NUM_BINS; i++)
                bin_counts[c][i] = '0;
        end
        sat_seen = 1'b0;
    endtask

    task automatic step_histograms(input in_word_t w, output out_word_t rep);
        bin_t   idx [NUM_CH];
        count_t v;
        rep = '0;
        idx[CH_RED]   = w.red;
        idx[CH_GREEN] = w.green;
        idx[CH_BLUE]  = w.blue;
        idx[CH_GRAY]  = luma_bin(w.red, w.green, w.blue);
        case (w.kind)
            KIND_ACC:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    v = bin_counts[c][idx[c]];
                    if (v != CNT_MAX)
                        v = v + 1'b1;
                    if (v == CNT_MAX)
                        sat_seen = 1'b1;
                    bin_counts[c][idx[c]] = v;
                    if (v > peak_counts[c])
                        peak_counts[c] = v;
                end
            end
            KIND_READ:
            begin
                rep.red_count   = bin_counts[CH_RED][w.bin];
                rep.green_count = bin_counts[CH_GREEN][w.bin];
                rep.blue_count  = bin_counts[CH_BLUE][w.bin];
                rep.gray_count  = bin_counts[CH_GRAY][w.bin];
            end
            KIND_CLEAR:
                clear_histograms();
            default:
                ;
        endcase
        rep.peak_red   = peak_counts[CH_RED];
        rep.peak_green = peak_counts[CH_GREEN];
        rep.peak_blue  = peak_counts[CH_BLUE];
        rep.peak_gray  = peak_counts[CH_GRAY];
        rep.saturated  = sat_seen;
    endtask

    task automatic push_word(input logic [KIND_BITS-1:0] kind,
                             input logic [PIX_BITS-1:0] r, g, b, bin);
        in_word_t w;
        w.kind  = kind;
        w.red   = r;
        w.green = g;
        w.blue  = b;
        w.bin   = bin;
        item_words_q.push_back(w);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        err_count++;
    endtask

    initial
    begin
        in_word_t w;
        int       sel;
        int       p;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        clear_histograms();
        for (int i = 0; i < NUM_COLORS; i++)
            for (int c = 0; c < 3; c++)
                palette[i][c] = PIX_BITS'($urandom_range(0, 255));

        // empty bins, corner pixels, repeated bins, no-op, clear
        push_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h00);
        push_word(KIND_READ, 8'hff, 8'hff, 8'hff, 8'hff);
        push_word(KIND_ACC, 8'h00, 8'h00, 8'h00, 8'hff);
        push_word(KIND_ACC, 8'hff, 8'hff, 8'hff, 8'h00);
        push_word(KIND_ACC, 8'hff, 8'h00, 8'h00, 8'h5a);
        push_word(KIND_ACC, 8'h00, 8'hff, 8'h00, 8'ha5);
        push_word(KIND_ACC, 8'h00, 8'h00, 8'hff, 8'h00);
        push_word(KIND_ACC, 8'h80, 8'h40, 8'h20, 8'h00);
        push_word(KIND_ACC, 8'h80, 8'h40, 8'h20, 8'hff);
        push_word(KIND_ACC, 8'h80, 8'h40, 8'h20, 8'h00);
        push_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h00);
        push_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'hff);
        push_word(KIND_READ, 8'hff, 8'hff, 8'hff, 8'h80);
        push_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h40);
        push_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h20);
        push_word(KIND_READ, 8'h00, 8'h00, 8'h00, luma_bin(8'h80, 8'h40, 8'h20));
        push_word(KIND_NOP, 8'h5a, 8'ha5, 8'hff, 8'h80);
        push_word(KIND_CLEAR, 8'ha5, 8'h5a, 8'h00, 8'hff);
        push_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h80);
        push_word(KIND_ACC, 8'h80, 8'h40, 8'h20, 8'h00);
        push_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h80);

        // mostly pixels from a small palette so bins and peaks build up
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            w.red   = PIX_BITS'($urandom_range(0, 255));
            w.green = PIX_BITS'($urandom_range(0, 255));
            w.blue  = PIX_BITS'($urandom_range(0, 255));
            w.bin   = PIX_BITS'($urandom_range(0, 255));
            sel     = $urandom_range(0, 99);
            p       = $urandom_range(0, NUM_COLORS - 1);
            if (sel < 2)
                w.kind = KIND_CLEAR;
            else if (sel < 5)
                w.kind = KIND_NOP;
            else if (sel < 25)
            begin
                w.kind = KIND_READ;
                case ($urandom_range(0, 4))
                    0, 1, 2: w.bin = palette[p][$urandom_range(0, 2)];
                    3:       w.bin = luma_bin(palette[p][0], palette[p][1], palette[p][2]);
                    default: ;
                endcase
            end
            else
            begin
                w.kind = KIND_ACC;
                if ($urandom_range(0, 3) != 0)
                begin
                    w.red   = palette[p][0];
                    w.green = palette[p][1];
                    w.blue  = palette[p][2];
                end
            end
            item_words_q.push_back(w);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (item_words_q.size() != 0 || item_ch.valid || expected_reports_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // item driver
    always @(negedge clk)
    begin
        logic     nv;
        in_word_t nd;
        nv = item_ch.valid;
        nd = item_ch.data;
        if (!rst_n)
            nv = 1'b0;
        else
        begin
            if (item_ch.valid && items_taken != src_seen)
            begin
                src_seen = items_taken;
                nv = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    src_quiet = !src_quiet;
                src_gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!nv)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (item_words_q.size() != 0)
                begin
                    nd = item_words_q.pop_front();
                    nv = 1'b1;
                end
            end
        end
        item_ch.valid <= nv;
        item_ch.data  <= nd;
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (results_taken != snk_seen)
        begin
            snk_seen = results_taken;
            if ($urandom_range(0, 31) == 0)
                snk_quiet = !snk_quiet;
            snk_stall = snk_quiet ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (snk_stall > 0)
        begin
            snk_stall--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        out_word_t   want;
        out_word_t   got;
        logic [31:0] got_f [NUM_FIELDS];
        logic [31:0] want_f [NUM_FIELDS];
        if (item_ch.valid && item_ch.ready)
        begin
            step_histograms(item_ch.data, want);
            expected_reports_q.push_back(want);
            items_taken++;
        end
        if (result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (expected_reports_q.size() == 0)
                report_mismatch($sformatf("word %0d arrived with nothing pending",
                                          results_taken));
            else
            begin
                want   = expected_reports_q.pop_front();
                got_f  = '{32'(got.red_count), 32'(got.green_count), 32'(got.blue_count),
                           32'(got.gray_count), 32'(got.peak_red), 32'(got.peak_green),
                           32'(got.peak_blue), 32'(got.peak_gray), 32'(got.saturated)};
                want_f = '{32'(want.red_count), 32'(want.green_count),
                           32'(want.blue_count), 32'(want.gray_count),
                           32'(want.peak_red), 32'(want.peak_green), 32'(want.peak_blue),
                           32'(want.peak_gray), 32'(want.saturated)};
                for (int f = 0; f < NUM_FIELDS; f++)
                    if (got_f[f] !== want_f[f])
                        report_mismatch($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                                                  results_taken, field_names[f],
                                                  got_f[f], want_f[f]));
            end
            results_taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
